// ----- hw/rtl/chd_pkg.sv -----
// chd_pkg: types and constants shared by the context Huffman decoder modules.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package chd_pkg;

  localparam logic [1:0] CMD_CHILD = 2'd0;
  localparam logic [1:0] CMD_ROOT  = 2'd1;
  localparam logic [1:0] CMD_DATA  = 2'd2;

  localparam logic [1:0] K_CHILD = 2'd0;
  localparam logic [1:0] K_ROOT  = 2'd1;
  localparam logic [1:0] K_DATA  = 2'd2;

  localparam int NODE_W      = 9;
  localparam int HDR_BYTES   = 4;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  typedef struct packed {
    logic [1:0]        kind;
    logic [7:0]        ctx;
    logic [7:0]        node_lo;
    logic              branch;
    logic [NODE_W-1:0] value;
    logic [7:0]        data;
    logic              fstart;
  } chd_entry_t;

endpackage
`default_nettype wire

// ----- hw/rtl/context_huffman_decoder.sv -----
// context_huffman_decoder: top level, front classifier, entry queue and back end.
// Depends on chd_pkg, chd_front, chd_queue, chd_back.
//
//   channel | handshake            | payload
//   input   | in_valid / in_stall  | cmd, context_req, inner_node, branch,
//           |                      | entry_value, data_byte, frame_start
//   output  | out_valid / out_stall| symbol, last
//
// Table writes, ignored bytes and header bytes are each handled as they are popped; the
// last header byte also reads the root table for context 0 and lands it in S_LAND.
// A code byte is popped, then walked in S_WALK with one table read per bit and an extra
// step per decoded symbol; a child read on the last bit is landed in S_LAND; a block
// that ends inside a byte drops the remaining bits.
// Reset (rst, synchronous) clears control state; tables are undefined until written.
// The front stalls only when the four-entry queue is full; out_stall holds the back end
// only when a symbol is ready and the result register is still occupied.
`timescale 1ns / 1ps
`default_nettype none
module context_huffman_decoder
  import chd_pkg::*;
#(
  parameter int COUNT_BITS = 32
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic [1:0]        cmd,
  input  wire logic [7:0]        context_req,
  input  wire logic [NODE_W-1:0] inner_node,
  input  wire logic              branch,
  input  wire logic [NODE_W-1:0] entry_value,
  input  wire logic [7:0]        data_byte,
  input  wire logic              frame_start,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic [7:0]             symbol,
  output logic                   last
);

  logic       push;
  chd_entry_t push_entry;
  logic       q_full;
  logic       q_valid;
  chd_entry_t q_entry;
  logic       pop;

  chd_front u_front (
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .cmd         (cmd),
    .context_req (context_req),
    .inner_node  (inner_node),
    .branch      (branch),
    .entry_value (entry_value),
    .data_byte   (data_byte),
    .frame_start (frame_start),
    .push        (push),
    .push_entry  (push_entry),
    .q_full      (q_full)
  );

  chd_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .full       (q_full),
    .q_valid    (q_valid),
    .q_entry    (q_entry),
    .pop        (pop)
  );

  chd_back #(
    .COUNT_BITS (COUNT_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_entry   (q_entry),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .symbol    (symbol),
    .last      (last)
  );

endmodule
`default_nettype wire

// ----- hw/rtl/chd_front.sv -----
// chd_front: accepts input items, drops no-op commands and packs the rest
// into queue entries. Depends on chd_pkg.
`timescale 1ns / 1ps
`default_nettype none
module chd_front
  import chd_pkg::*;
(
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic [1:0]        cmd,
  input  wire logic [7:0]        context_req,
  input  wire logic [NODE_W-1:0] inner_node,
  input  wire logic              branch,
  input  wire logic [NODE_W-1:0] entry_value,
  input  wire logic [7:0]        data_byte,
  input  wire logic              frame_start,
  output logic                   push,
  output chd_entry_t             push_entry,
  input  wire logic              q_full
);

  logic keep;

  always_comb begin
    keep                = 1'b0;
    push_entry.kind     = K_DATA;
    push_entry.ctx      = context_req;
    push_entry.node_lo  = inner_node[7:0];
    push_entry.branch   = branch;
    push_entry.value    = entry_value;
    push_entry.data     = data_byte;
    push_entry.fstart   = frame_start;
    case (cmd)
      CMD_CHILD: begin
        push_entry.kind = K_CHILD;
        keep            = inner_node[NODE_W-1];
      end
      CMD_ROOT: begin
        push_entry.kind = K_ROOT;
        keep            = 1'b1;
      end
      CMD_DATA: begin
        push_entry.kind = K_DATA;
        keep            = 1'b1;
      end
      default: keep = 1'b0;
    endcase
  end

  assign in_stall = q_full;
  assign push     = in_valid && !q_full && keep;

endmodule
`default_nettype wire

// ----- hw/rtl/chd_queue.sv -----
// chd_queue: short entry queue between front and back.
// Depends on chd_pkg.
`timescale 1ns / 1ps
`default_nettype none
module chd_queue
  import chd_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       push,
  input  wire chd_entry_t push_entry,
  output logic            full,
  output logic            q_valid,
  output chd_entry_t      q_entry,
  input  wire logic       pop
);

  chd_entry_t        slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   fill;

  assign full    = (fill == (QPTR_W+1)'(QUEUE_DEPTH));
  assign q_valid = (fill != '0);
  assign q_entry = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

// ----- hw/rtl/chd_back.sv -----
// chd_back: executes queue entries: table writes, header parsing, tree walk.
// Holds the child and root tables and the result register. Depends on chd_pkg.
`timescale 1ns / 1ps
`default_nettype none
module chd_back
  import chd_pkg::*;
#(
  parameter int COUNT_BITS = 32
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       q_valid,
  input  wire chd_entry_t q_entry,
  output logic            pop,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [7:0]      symbol,
  output logic            last
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_WALK = 2'd1;
  localparam logic [1:0] S_LAND = 2'd2;

  localparam logic [1:0] SRC_CUR   = 2'd0;
  localparam logic [1:0] SRC_CHILD = 2'd1;
  localparam logic [1:0] SRC_ROOT  = 2'd2;

  logic [NODE_W-1:0] child_mem [1 << 17];
  logic [NODE_W-1:0] root_mem  [256];
  logic [NODE_W-1:0] child_q;
  logic [NODE_W-1:0] root_q;

  logic                  child_we, child_re, root_we, root_re;
  logic [16:0]           child_waddr, child_raddr;
  logic [7:0]            root_waddr, root_raddr;

  logic [1:0]            state, state_next;
  logic [1:0]            src, src_next;
  logic [2:0]            bit_idx, bit_idx_next;
  logic [7:0]            data_reg, data_reg_next;
  logic [NODE_W-1:0]     cur_node, cur_node_next;
  logic [7:0]            ctx, ctx_next;
  logic [COUNT_BITS-1:0] count, count_next;
  logic [2:0]            hdr, hdr_next;
  logic                  active, active_next;
  logic                  out_valid_next;
  logic [7:0]            symbol_next;
  logic                  last_next;

  logic [NODE_W-1:0]     node;
  logic                  out_free;
  logic [2:0]            hdr_eff;
  logic [COUNT_BITS-1:0] cnt_eff;
  logic [31:0]           hdr_word;
  logic [COUNT_BITS-1:0] cnt_or;

  always_ff @(posedge clk) begin
    if (child_we) begin
      child_mem[child_waddr] <= q_entry.value;
    end
    if (child_re) begin
      child_q <= child_mem[child_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (root_we) begin
      root_mem[root_waddr] <= q_entry.value;
    end
    if (root_re) begin
      root_q <= root_mem[root_raddr];
    end
  end

  always_comb begin
    case (src)
      SRC_CHILD: node = child_q;
      SRC_ROOT:  node = root_q;
      default:   node = cur_node;
    endcase
  end

  assign out_free    = !out_valid || !out_stall;
  assign hdr_eff     = q_entry.fstart ? 3'd0 : hdr;
  assign cnt_eff     = q_entry.fstart ? '0 : count;
  assign hdr_word    = 32'(q_entry.data) << {hdr_eff[1:0], 3'b000};
  assign cnt_or      = cnt_eff | hdr_word[COUNT_BITS-1:0];
  assign child_waddr = {q_entry.ctx, q_entry.node_lo, q_entry.branch};
  assign root_waddr  = q_entry.ctx;

  always_comb begin
    state_next     = state;
    src_next       = src;
    bit_idx_next   = bit_idx;
    data_reg_next  = data_reg;
    cur_node_next  = cur_node;
    ctx_next       = ctx;
    count_next     = count;
    hdr_next       = hdr;
    active_next    = active;
    out_valid_next = out_valid && out_stall;
    symbol_next    = symbol;
    last_next      = last;
    pop            = 1'b0;
    child_we       = 1'b0;
    root_we        = 1'b0;
    child_re       = 1'b0;
    root_re        = 1'b0;
    child_raddr    = {ctx, node[7:0], data_reg[bit_idx]};
    root_raddr     = node[7:0];

    case (state)
      S_IDLE: begin
        if (q_valid) begin
          pop = 1'b1;
          case (q_entry.kind)
            K_CHILD: child_we = 1'b1;
            K_ROOT:  root_we  = 1'b1;
            K_DATA: begin
              if (q_entry.fstart || active) begin
                if (hdr_eff < 3'(HDR_BYTES)) begin
                  count_next  = cnt_or;
                  hdr_next    = hdr_eff + 3'd1;
                  active_next = 1'b1;
                  if (hdr_eff == 3'(HDR_BYTES - 1)) begin
                    ctx_next    = '0;
                    root_re     = 1'b1;
                    root_raddr  = '0;
                    src_next    = SRC_ROOT;
                    state_next  = S_LAND;
                    active_next = (cnt_or != '0);
                  end
                end else begin
                  data_reg_next = q_entry.data;
                  bit_idx_next  = '0;
                  src_next      = SRC_CUR;
                  state_next    = S_WALK;
                end
              end
            end
            default: pop = 1'b1;
          endcase
        end
      end
      S_WALK: begin
        if (!node[NODE_W-1] && src != SRC_ROOT) begin
          if (out_free) begin
            out_valid_next = 1'b1;
            symbol_next    = node[7:0];
            count_next     = count - COUNT_BITS'(1);
            if (count == COUNT_BITS'(1)) begin
              last_next   = 1'b1;
              active_next = 1'b0;
              state_next  = S_IDLE;
            end else begin
              last_next = 1'b0;
              ctx_next  = node[7:0];
              root_re   = 1'b1;
              src_next  = SRC_ROOT;
            end
          end
        end else if (!node[NODE_W-1]) begin
          cur_node_next = node;
          src_next      = SRC_CUR;
          if (bit_idx == 3'd7) begin
            state_next = S_IDLE;
          end else begin
            bit_idx_next = bit_idx + 3'd1;
          end
        end else begin
          child_re = 1'b1;
          src_next = SRC_CHILD;
          if (bit_idx == 3'd7) begin
            state_next = S_LAND;
          end else begin
            bit_idx_next = bit_idx + 3'd1;
          end
        end
      end
      S_LAND: begin
        cur_node_next = node;
        src_next      = SRC_CUR;
        state_next    = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      src       <= SRC_CUR;
      bit_idx   <= '0;
      cur_node  <= '0;
      ctx       <= '0;
      count     <= '0;
      hdr       <= '0;
      active    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      src       <= src_next;
      bit_idx   <= bit_idx_next;
      cur_node  <= cur_node_next;
      ctx       <= ctx_next;
      count     <= count_next;
      hdr       <= hdr_next;
      active    <= active_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    data_reg <= data_reg_next;
    symbol   <= symbol_next;
    last     <= last_next;
  end

endmodule
`default_nettype wire

// ----- bench/context_huffman_decoder_tb.sv -----
// Self-checking bench for context_huffman_decoder: loads per-context code trees, streams
// compressed blocks and checks every decoded symbol against an in-bench predictor.
// Depends on chd_pkg and the context_huffman_decoder RTL.
`timescale 1ns / 1ps
module context_huffman_decoder_tb;
  import chd_pkg::*;

  localparam int COUNT_BITS = 32;
  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int HOLD_CYCLES = 400;
  localparam int QUIET_LIMIT = 5000;
  localparam int DRAIN_CYCLES = 200;
  localparam int PHASE_BYTES = 24;

  typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;

  typedef struct packed {
    logic [1:0]        op;
    logic [7:0]        ctx;
    logic [NODE_W-1:0] node;
    logic              br;
    logic [NODE_W-1:0] val;
    logic [7:0]        data;
    logic              fs;
  } req_t;

  typedef struct packed {
    logic [7:0] sym;
    logic       last;
  } sym_out_t;

  class huff_scoreboard;
    bit [NODE_W-1:0] child_mem [131072];
    bit [NODE_W-1:0] root_mem [256];
    bit [NODE_W-1:0] cur_node;
    bit [7:0] cur_ctx;
    bit [31:0] hdr_acc;
    bit [COUNT_BITS-1:0] remaining;
    int hdr_seen;
    bit block_open;
    sym_out_t expected [$];
    int errors;

    function void note_input(req_t r);
      bit [NODE_W-1:0] nd;
      if (r.op == CMD_CHILD) begin
        if (r.node[8]) child_mem[{r.ctx, r.node[7:0], r.br}] = r.val;
        return;
      end
      if (r.op == CMD_ROOT) begin
        root_mem[r.ctx] = r.val;
        return;
      end
      if (r.op != CMD_DATA) return;
      if (r.fs) begin
        block_open = 1'b1;
        hdr_seen = 0;
        hdr_acc = '0;
      end
      if (!block_open) return;
      if (hdr_seen < HDR_BYTES) begin
        hdr_acc |= 32'(r.data) << (8 * hdr_seen);
        hdr_seen++;
        if (hdr_seen == HDR_BYTES) begin
          remaining = hdr_acc[COUNT_BITS-1:0];
          cur_ctx = 8'd0;
          cur_node = root_mem[0];
          if (remaining == 0) block_open = 1'b0;
        end
        return;
      end
      for (int b = 0; b < 8; b++) begin
        nd = cur_node;
        if (!nd[8]) begin
          remaining = remaining - 1'b1;
          expected.push_back('{sym: nd[7:0], last: (remaining == 0)});
          if (remaining == 0) begin
            block_open = 1'b0;
            return;
          end
          cur_ctx = nd[7:0];
          nd = root_mem[nd[7:0]];
        end
        if (nd[8]) nd = child_mem[{cur_ctx, nd[7:0], r.data[b]}];
        cur_node = nd;
      end
    endfunction

    function void check_result(logic [7:0] s, logic l);
      sym_out_t e;
      if (expected.size() == 0) begin
        $error("symbol %0d arrived with nothing expected", s);
        errors++;
        return;
      end
      e = expected.pop_front();
      if (s !== e.sym) begin
        $error("symbol: expected %0d, actual %0d", e.sym, s);
        errors++;
      end
      if (l !== e.last) begin
        $error("last: expected %0d, actual %0d", e.last, l);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] cmd = '0;
  logic [7:0] context_req = '0;
  logic [NODE_W-1:0] inner_node = '0;
  logic branch = 1'b0;
  logic [NODE_W-1:0] entry_value = '0;
  logic [7:0] data_byte = '0;
  logic frame_start = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [7:0] symbol;
  logic last;

  idle_mode_t mode = IDLE_NONE;
  bit hold_go = 1'b0;
  bit hold_done = 1'b0;
  int hold_left = 0;
  int quiet = 0;
  bit in_set [256];
  bit [15:0] tree_nodes [$];
  huff_scoreboard board = new;

  context_huffman_decoder #(.COUNT_BITS(COUNT_BITS)) u_top (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .cmd(cmd), .context_req(context_req), .inner_node(inner_node), .branch(branch),
    .entry_value(entry_value), .data_byte(data_byte), .frame_start(frame_start),
    .out_valid(out_valid), .out_stall(out_stall),
    .symbol(symbol), .last(last)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_go && !hold_done) begin
      hold_done <= 1'b1;
      hold_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else if (mode == IDLE_RECV) begin
      out_stall <= ($urandom_range(0, 99) < 82);
    end else if (mode == IDLE_BOTH) begin
      out_stall <= ($urandom_range(0, 99) < 12);
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) board.check_result(symbol, last);
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet <= 0;
    end else if (quiet == QUIET_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  function automatic req_t filler(logic [1:0] op);
    req_t r;
    r.op = op;
    r.ctx = 8'($urandom);
    r.node = 9'($urandom_range(256, 510));
    r.br = 1'($urandom);
    r.val = 9'($urandom_range(0, 510));
    r.data = 8'($urandom);
    r.fs = 1'($urandom);
    return r;
  endfunction

  task automatic offer(req_t r);
    int pct;
    pct = (mode == IDLE_SEND) ? 82 : (mode == IDLE_BOTH) ? 12 : 0;
    while ($urandom_range(0, 99) < pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    cmd <= r.op;
    context_req <= r.ctx;
    inner_node <= r.node;
    branch <= r.br;
    entry_value <= r.val;
    data_byte <= r.data;
    frame_start <= r.fs;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    board.note_input(r);
  endtask

  task automatic write_child(logic [7:0] c, logic [NODE_W-1:0] nd, logic br,
                             logic [NODE_W-1:0] v);
    req_t r;
    r = filler(CMD_CHILD);
    r.ctx = c;
    r.node = nd;
    r.br = br;
    r.val = v;
    offer(r);
  endtask

  task automatic write_root(logic [7:0] c, logic [NODE_W-1:0] v);
    req_t r;
    r = filler(CMD_ROOT);
    r.ctx = c;
    r.val = v;
    offer(r);
  endtask

  task automatic send_byte(logic [7:0] d, logic fs);
    req_t r;
    r = filler(CMD_DATA);
    r.data = d;
    r.fs = fs;
    offer(r);
  endtask

  task automatic load_trees();
    bit [NODE_W-1:0] pool [$];
    bit [7:0] ctxs [$];
    bit [7:0] pick [$];
    bit taken [256];
    bit [NODE_W-1:0] a, b, nd;
    bit [7:0] t;
    int n, k, i, j;
    in_set = '{default: 1'b0};
    tree_nodes.delete();
    ctxs.push_back(8'd0);
    in_set[0] = 1'b1;
    n = $urandom_range(2, 5);
    while (ctxs.size() < n) begin
      t = 8'($urandom_range(1, 255));
      if (!in_set[t]) begin
        in_set[t] = 1'b1;
        ctxs.push_back(t);
      end
    end
    foreach (ctxs[c]) begin
      pick = ctxs;
      for (i = pick.size() - 1; i > 0; i--) begin
        j = $urandom_range(0, i);
        t = pick[i];
        pick[i] = pick[j];
        pick[j] = t;
      end
      k = $urandom_range(1, n);
      pool.delete();
      for (i = 0; i < k; i++) pool.push_back({1'b0, pick[i]});
      taken = '{default: 1'b0};
      while (pool.size() > 1) begin
        i = $urandom_range(0, pool.size() - 1);
        a = pool[i];
        pool.delete(i);
        i = $urandom_range(0, pool.size() - 1);
        b = pool[i];
        pool.delete(i);
        do nd = 9'($urandom_range(256, 510)); while (taken[nd[7:0]]);
        taken[nd[7:0]] = 1'b1;
        write_child(ctxs[c], nd, 1'b0, a);
        write_child(ctxs[c], nd, 1'b1, b);
        tree_nodes.push_back({ctxs[c], nd[7:0]});
        pool.push_back(nd);
      end
      write_root(ctxs[c], pool[0]);
    end
  endtask

  task automatic run_phase(idle_mode_t pm, bit press);
    req_t r;
    bit [31:0] count;
    bit [15:0] tn;
    bit [7:0] c;
    int budget, kind, nh, i;
    mode <= pm;
    load_trees();
    if (press) hold_go <= 1'b1;
    budget = 0;
    while (budget < PHASE_BYTES || board.block_open) begin
      kind = $urandom_range(0, 9);
      count = (kind < 8) ? $urandom_range(1, 24) : $urandom;
      if (kind == 8) count[31:24] = 8'($urandom_range(1, 255));
      nh = (kind == 9) ? $urandom_range(1, HDR_BYTES - 1) : HDR_BYTES;
      for (i = 0; i < nh; i++) send_byte(count[8*i +: 8], i == 0);
      if (kind < 8) begin
        while (board.block_open) begin
          if ($urandom_range(0, 7) == 0) begin
            do c = 8'($urandom); while (in_set[c]);
            case ($urandom_range(0, 4))
              0: write_child(c, 9'($urandom_range(256, 510)), 1'($urandom),
                             9'($urandom_range(0, 510)));
              1: write_root(c, 9'($urandom_range(0, 510)));
              2: offer(filler(CMD_UNUSED));
              3: begin
                r = filler(CMD_CHILD);
                r.node = 9'($urandom_range(0, 255));
                offer(r);
              end
              default: begin
                tn = tree_nodes.size() ? tree_nodes[$urandom_range(0, tree_nodes.size() - 1)]
                                       : 16'd0;
                if (tree_nodes.size()) begin
                  r.val = board.child_mem[{tn, 1'b0}];
                  r.node = board.child_mem[{tn, 1'b1}];
                  write_child(tn[15:8], {1'b1, tn[7:0]}, 1'b0, r.node);
                  write_child(tn[15:8], {1'b1, tn[7:0]}, 1'b1, r.val);
                end
              end
            endcase
          end
          send_byte(8'($urandom), 1'b0);
          budget++;
        end
        if ($urandom_range(0, 3) == 0) begin
          repeat ($urandom_range(1, 2)) send_byte(8'($urandom), 1'b0);
        end
      end else if (kind == 8) begin
        repeat ($urandom_range(1, 4)) begin
          send_byte(8'($urandom), 1'b0);
          budget++;
        end
      end
    end
  endtask

  initial begin
    req_t r;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    offer(filler(CMD_UNUSED));
    r = filler(CMD_CHILD);
    r.ctx = 8'd0;
    r.node = 9'd255;
    r.val = 9'd510;
    offer(r);
    write_child(8'd0, 9'd510, 1'b0, 9'd256);
    write_child(8'd0, 9'd510, 1'b1, 9'd255);
    write_child(8'd0, 9'd256, 1'b0, 9'd0);
    write_child(8'd0, 9'd256, 1'b1, 9'd255);
    write_root(8'd0, 9'd510);
    write_root(8'd255, 9'd255);
    send_byte(8'h3C, 1'b0);
    send_byte(8'h00, 1'b1);
    repeat (3) send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b1);
    repeat (3) send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h03, 1'b1);
    repeat (3) send_byte(8'h00, 1'b0);
    send_byte(8'hA5, 1'b0);
    send_byte(8'h5A, 1'b0);

    run_phase(IDLE_NONE, 1'b1);
    run_phase(IDLE_SEND, 1'b0);
    run_phase(IDLE_RECV, 1'b0);
    run_phase(IDLE_BOTH, 1'b0);
    run_phase(IDLE_NONE, 1'b0);

    in_valid <= 1'b0;
    mode <= IDLE_NONE;
    while (board.expected.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (board.errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
